>>> hw/rtl/spi_memory_command_sequencer_assert.svh
// assertion macros for the serial memory command sequencer
`ifndef SPI_MEMORY_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_MEMORY_COMMAND_SEQUENCER_ASSERT_SVH

// same-cycle implication under reset
`define SMCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smcs same-cycle check failed");

// next-cycle implication under reset
`define SMCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smcs next-cycle check failed");

`endif

>>> hw/rtl/smcs_pkg.sv
// shared types, codes and tables for the serial memory command sequencer
package smcs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W       = 17;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TX    = 2'd1;
    localparam logic [1:0] REQ_RX    = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [2:0] KIND_RAM_WRITE   = 3'd0;
    localparam logic [2:0] KIND_FLASH_WRITE = 3'd1;
    localparam logic [2:0] KIND_RAM_READ    = 3'd2;
    localparam logic [2:0] KIND_FLASH_READ  = 3'd3;
    localparam logic [2:0] KIND_UNPROTECT   = 3'd4;
    localparam logic [2:0] KIND_WREN        = 3'd5;
    localparam logic [2:0] KIND_WRSR0       = 3'd6;
    localparam logic [2:0] KIND_RDSR        = 3'd7;

    localparam logic [7:0] OP_WREN        = 8'h06;
    localparam logic [7:0] OP_RDSR        = 8'h05;
    localparam logic [7:0] OP_WRSR        = 8'h01;
    localparam logic [7:0] OP_READ        = 8'h03;
    localparam logic [7:0] OP_RAM_WRITE   = 8'h02;
    localparam logic [7:0] OP_FLASH_WRITE = 8'h0A;
    localparam logic [7:0] STATUS_ZERO    = 8'h00;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  command;
        logic [23:0] mem_address;
        logic [15:0] byte_count;
        logic [7:0]  data_byte;
    } req_word_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_byte;
        logic        last_of_stream;
        logic        select_active;
        logic        tx_done;
        logic        rx_done;
    } rsp_word_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [2:0]       kind;
        logic [23:0]      addr;
        logic [2:0]       hdr;
        logic [CNT_W-1:0] total;
        logic [7:0]       data;
    } entry_t;

    function automatic logic [2:0] kind_header_len(input logic [2:0] kind);
        logic [2:0] n;
        begin
            case (kind)
                KIND_RAM_WRITE:   n = 3'd3;
                KIND_FLASH_WRITE: n = 3'd4;
                KIND_RAM_READ:    n = 3'd3;
                KIND_FLASH_READ:  n = 3'd4;
                KIND_UNPROTECT:   n = 3'd3;
                KIND_WREN:        n = 3'd1;
                KIND_WRSR0:       n = 3'd2;
                default:          n = 3'd1;
            endcase
            return n;
        end
    endfunction

    function automatic logic [7:0] kind_opcode(input logic [2:0] kind);
        logic [7:0] op;
        begin
            case (kind)
                KIND_RAM_WRITE:   op = OP_RAM_WRITE;
                KIND_FLASH_WRITE: op = OP_FLASH_WRITE;
                KIND_RAM_READ:    op = OP_READ;
                KIND_FLASH_READ:  op = OP_READ;
                KIND_UNPROTECT:   op = OP_WREN;
                KIND_WREN:        op = OP_WREN;
                KIND_WRSR0:       op = OP_WRSR;
                default:          op = OP_RDSR;
            endcase
            return op;
        end
    endfunction

    function automatic logic [7:0] header_byte(input logic [2:0] kind, input logic [1:0] idx,
                                               input logic [23:0] addr);
        logic [7:0] b;
        begin
            b = STATUS_ZERO;
            if (idx == 2'd0)
            begin
                b = kind_opcode(kind);
            end
            else
            begin
                case (kind)
                    KIND_RAM_WRITE, KIND_RAM_READ:
                        b = (idx == 2'd1) ? addr[15:8] : addr[7:0];
                    KIND_FLASH_WRITE, KIND_FLASH_READ:
                        b = (idx == 2'd1) ? addr[23:16] :
                            (idx == 2'd2) ? addr[15:8] : addr[7:0];
                    KIND_UNPROTECT:
                        b = (idx == 2'd1) ? OP_WRSR : STATUS_ZERO;
                    default:
                        b = STATUS_ZERO;
                endcase
            end
            return b;
        end
    endfunction

    function automatic logic kind_writes(input logic [2:0] kind);
        return kind inside {KIND_RAM_WRITE, KIND_FLASH_WRITE};
    endfunction

    function automatic logic kind_reads(input logic [2:0] kind);
        return kind inside {KIND_RAM_READ, KIND_FLASH_READ, KIND_RDSR};
    endfunction

endpackage

>>> hw/rtl/smcs_front.sv
// front end: accepts request words, drops unused codes, precomputes frame lengths
module smcs_front
    import smcs_pkg::*;
(
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req_word,
    input  logic      q_full,
    output logic      push,
    output entry_t    push_entry
);

    logic [15:0] data_len;
    logic [2:0]  hdr;

    always_comb
    begin
        hdr = kind_header_len(req_word.command);
        if (req_word.command inside {KIND_RAM_WRITE, KIND_FLASH_WRITE,
                                     KIND_RAM_READ, KIND_FLASH_READ})
        begin
            data_len = req_word.byte_count;
        end
        else if (req_word.command == KIND_RDSR)
        begin
            data_len = 16'd1;
        end
        else
        begin
            data_len = 16'd0;
        end
    end

    assign req_stall = q_full;
    assign push      = req_valid && !q_full && (req_word.req_type != REQ_NONE);

    always_comb
    begin
        push_entry.op    = req_word.req_type;
        push_entry.kind  = req_word.command;
        push_entry.addr  = req_word.mem_address;
        push_entry.hdr   = hdr;
        push_entry.total = {1'b0, data_len} + {{(CNT_W-3){1'b0}}, hdr};
        push_entry.data  = req_word.data_byte;
    end

endmodule

>>> hw/rtl/smcs_queue.sv
// short fifo of classified words between front and back
module smcs_queue
    import smcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   q_valid,
    output logic   q_full,
    output entry_t q_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    entry_t             store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0] count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CNT_W_Q'(DEPTH));
    assign q_entry = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hw/rtl/smcs_back.sv
// back end: transaction state, byte framing and the output register
module smcs_back
    import smcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  entry_t    q_entry,
    output logic      pop,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    logic [2:0]       kind_reg, kind_next;
    logic [23:0]      addr_reg, addr_next;
    logic [2:0]       hdr_reg, hdr_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [1:0]       tx_phase_reg, tx_phase_next;
    logic [1:0]       rx_phase_reg, rx_phase_next;
    logic [CNT_W-1:0] tx_cnt_reg, tx_cnt_next;
    logic [CNT_W-1:0] rx_cnt_reg, rx_cnt_next;
    logic             select_reg, select_next;
    logic             tx_done_reg, tx_done_next;
    logic             rx_done_reg, rx_done_next;
    logic             out_valid_reg, out_valid_next;
    rsp_word_t        out_word_reg, out_word_next;

    logic             has_result;
    logic [CNT_W-1:0] hdr_ext;
    logic [CNT_W-1:0] tx_inc;
    logic [CNT_W-1:0] rx_inc;
    logic             tx_active;
    logic             rx_active;

    assign pop       = q_valid && (!out_valid_reg || !rsp_stall);
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    assign hdr_ext   = {{(CNT_W-3){1'b0}}, hdr_reg};
    assign tx_inc    = tx_cnt_reg + 1'b1;
    assign rx_inc    = rx_cnt_reg + 1'b1;
    assign tx_active = (tx_phase_reg == PH_HEADER) || (tx_phase_reg == PH_DATA);
    assign rx_active = (rx_phase_reg == PH_HEADER) || (rx_phase_reg == PH_DATA);

    always_comb
    begin
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        hdr_next      = hdr_reg;
        total_next    = total_reg;
        tx_phase_next = tx_phase_reg;
        rx_phase_next = rx_phase_reg;
        tx_cnt_next   = tx_cnt_reg;
        rx_cnt_next   = rx_cnt_reg;
        select_next   = select_reg;
        tx_done_next  = tx_done_reg;
        rx_done_next  = rx_done_reg;
        has_result    = 1'b0;
        out_word_next = out_word_reg;

        if (pop)
        begin
            case (q_entry.op)
                REQ_START:
                begin
                    kind_next     = q_entry.kind;
                    addr_next     = q_entry.addr;
                    hdr_next      = q_entry.hdr;
                    total_next    = q_entry.total;
                    tx_phase_next = PH_HEADER;
                    rx_phase_next = PH_HEADER;
                    tx_cnt_next   = '0;
                    rx_cnt_next   = '0;
                    select_next   = 1'b1;
                    tx_done_next  = 1'b0;
                    rx_done_next  = 1'b0;
                end
                REQ_TX:
                begin
                    if (tx_active)
                    begin
                        has_result                   = 1'b1;
                        out_word_next.out_kind       = 1'b0;
                        out_word_next.last_of_stream = 1'b0;
                        if (tx_cnt_reg < hdr_ext)
                        begin
                            out_word_next.out_byte = header_byte(kind_reg, tx_cnt_reg[1:0],
                                                                 addr_reg);
                        end
                        else
                        begin
                            out_word_next.out_byte = kind_writes(kind_reg) ? q_entry.data
                                                                           : STATUS_ZERO;
                        end
                        tx_cnt_next = tx_inc;
                        if (tx_inc >= total_reg)
                        begin
                            tx_phase_next                = PH_DONE;
                            tx_done_next                 = 1'b1;
                            out_word_next.last_of_stream = 1'b1;
                        end
                        else if (tx_inc >= hdr_ext)
                        begin
                            tx_phase_next = PH_DATA;
                        end
                    end
                end
                REQ_RX:
                begin
                    if (rx_active)
                    begin
                        has_result                   = kind_reads(kind_reg) &&
                                                       (rx_cnt_reg >= hdr_ext);
                        out_word_next.out_kind       = 1'b1;
                        out_word_next.out_byte       = q_entry.data;
                        out_word_next.last_of_stream = 1'b0;
                        rx_cnt_next                  = rx_inc;
                        if (rx_inc >= total_reg)
                        begin
                            rx_phase_next                = PH_DONE;
                            rx_done_next                 = 1'b1;
                            select_next                  = 1'b0;
                            out_word_next.last_of_stream = 1'b1;
                        end
                        else if (rx_inc >= hdr_ext)
                        begin
                            rx_phase_next = PH_DATA;
                        end
                    end
                end
                default:
                begin
                    has_result = 1'b0;
                end
            endcase
        end

        out_word_next.select_active = select_next;
        out_word_next.tx_done       = tx_done_next;
        out_word_next.rx_done       = rx_done_next;

        if (pop)
        begin
            out_valid_next = has_result;
        end
        else
        begin
            out_valid_next = out_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_RAM_WRITE;
            addr_reg      <= '0;
            hdr_reg       <= '0;
            total_reg     <= '0;
            tx_phase_reg  <= PH_IDLE;
            rx_phase_reg  <= PH_IDLE;
            tx_cnt_reg    <= '0;
            rx_cnt_reg    <= '0;
            select_reg    <= 1'b0;
            tx_done_reg   <= 1'b0;
            rx_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kind_reg      <= kind_next;
            addr_reg      <= addr_next;
            hdr_reg       <= hdr_next;
            total_reg     <= total_next;
            tx_phase_reg  <= tx_phase_next;
            rx_phase_reg  <= rx_phase_next;
            tx_cnt_reg    <= tx_cnt_next;
            rx_cnt_reg    <= rx_cnt_next;
            select_reg    <= select_next;
            tx_done_reg   <= tx_done_next;
            rx_done_reg   <= rx_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && has_result)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

>>> hw/rtl/spi_memory_command_sequencer.sv
// top level of the serial memory command sequencer
// Takes one request word per cycle while req_stall is low and gives at most one
// response word per request. A request passes the front end straight into a
// QUEUE_DEPTH-entry fifo; the back end takes one fifo entry per cycle, unless a held
// response stalls it, into the frame state and then the response register. Sustained
// rate is one word per clock on both sides when neither stalls; the response register
// and the fifo let either side stall without stopping the other until the fifo fills.
`include "spi_memory_command_sequencer_assert.svh"

module spi_memory_command_sequencer
    import smcs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    logic   q_full;
    logic   q_valid;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t q_entry;

    smcs_front u_front
    (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_word   (req_word),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    smcs_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .q_entry    (q_entry)
    );

    smcs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    // chip select is down once the receive side has finished
    `SMCS_ASSERT_NOW(a_rx_done_deselects, clk, rst_n,
        rsp_valid && rsp_word.rx_done, !rsp_word.select_active)

    // the last transmit byte reports transmit done
    `SMCS_ASSERT_NOW(a_tx_last_done, clk, rst_n,
        rsp_valid && !rsp_word.out_kind && rsp_word.last_of_stream, rsp_word.tx_done)

    // an accepted working request is held in the fifo on the next cycle
    `SMCS_ASSERT_NEXT(a_push_lands, clk, rst_n,
        req_valid && !req_stall && (req_word.req_type != REQ_NONE), q_valid)

endmodule

>>> dv/tb_spi_memory_command_sequencer.sv
`timescale 1ns / 1ps
// self-checking testbench for the serial memory command sequencer
module tb_spi_memory_command_sequencer;
    import smcs_pkg::*;

    localparam int ITEM_GOAL   = 1700;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 16;

    class frame_scoreboard;
        rsp_word_t   expected_bytes[$];
        logic [2:0]  cur_kind;
        logic [23:0] cur_addr;
        logic [15:0] cur_len;
        logic [1:0]  tx_state;
        logic [1:0]  rx_state;
        logic [16:0] tx_sent;
        logic [16:0] rx_seen;
        logic        cs_active;
        logic [1:0]  done_bits;
        int          mismatches;
        int          checked;

        function new();
            cur_kind   = KIND_RAM_WRITE;
            cur_addr   = '0;
            cur_len    = '0;
            tx_state   = PH_IDLE;
            rx_state   = PH_IDLE;
            tx_sent    = '0;
            rx_seen    = '0;
            cs_active  = 1'b0;
            done_bits  = 2'b00;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int header_length(logic [2:0] kind);
            int n;
            case (kind)
                KIND_FLASH_WRITE, KIND_FLASH_READ:             n = 4;
                KIND_RAM_WRITE, KIND_RAM_READ, KIND_UNPROTECT: n = 3;
                KIND_WRSR0:                                    n = 2;
                default:                                       n = 1;
            endcase
            return n;
        endfunction

        function logic [7:0] header_byte_at(int i);
            logic [7:0] b;
            b = STATUS_ZERO;
            if (i == 0)
            begin
                case (cur_kind)
                    KIND_RAM_WRITE:                  b = OP_RAM_WRITE;
                    KIND_FLASH_WRITE:                b = OP_FLASH_WRITE;
                    KIND_RAM_READ, KIND_FLASH_READ:  b = OP_READ;
                    KIND_UNPROTECT, KIND_WREN:       b = OP_WREN;
                    KIND_WRSR0:                      b = OP_WRSR;
                    default:                         b = OP_RDSR;
                endcase
            end
            else
            begin
                case (cur_kind)
                    KIND_RAM_WRITE, KIND_RAM_READ:     b = 8'(cur_addr >> (8 * (2 - i)));
                    KIND_FLASH_WRITE, KIND_FLASH_READ: b = 8'(cur_addr >> (8 * (3 - i)));
                    KIND_UNPROTECT:                    b = (i == 1) ? OP_WRSR : STATUS_ZERO;
                    default:                           b = STATUS_ZERO;
                endcase
            end
            return b;
        endfunction

        function void note_request(req_word_t w);
            int         hlen;
            int         total;
            int         idx;
            logic       last;
            logic       deliver;
            logic [7:0] b;
            rsp_word_t  r;
            hlen  = header_length(cur_kind);
            total = hlen + int'(cur_len);
            last  = 1'b0;
            case (w.req_type)
                REQ_START:
                begin
                    cur_kind = w.command;
                    cur_addr = w.mem_address;
                    if (w.command == KIND_RAM_WRITE || w.command == KIND_FLASH_WRITE ||
                        w.command == KIND_RAM_READ || w.command == KIND_FLASH_READ)
                        cur_len = w.byte_count;
                    else
                        cur_len = (w.command == KIND_RDSR) ? 16'd1 : 16'd0;
                    tx_state  = PH_HEADER;
                    rx_state  = PH_HEADER;
                    tx_sent   = '0;
                    rx_seen   = '0;
                    cs_active = 1'b1;
                    done_bits = 2'b00;
                end
                REQ_TX:
                begin
                    if (tx_state == PH_HEADER || tx_state == PH_DATA)
                    begin
                        idx = int'(tx_sent);
                        if (idx < hlen)
                            b = header_byte_at(idx);
                        else if (cur_kind == KIND_RAM_WRITE || cur_kind == KIND_FLASH_WRITE)
                            b = w.data_byte;
                        else
                            b = 8'h00;
                        tx_sent = tx_sent + 17'd1;
                        if (int'(tx_sent) >= total)
                        begin
                            tx_state     = PH_DONE;
                            done_bits[0] = 1'b1;
                            last         = 1'b1;
                        end
                        else if (int'(tx_sent) >= hlen)
                            tx_state = PH_DATA;
                        r = '{out_kind: 1'b0, out_byte: b, last_of_stream: last,
                              select_active: cs_active, tx_done: done_bits[0],
                              rx_done: done_bits[1]};
                        expected_bytes.push_back(r);
                    end
                end
                REQ_RX:
                begin
                    if (rx_state == PH_HEADER || rx_state == PH_DATA)
                    begin
                        idx     = int'(rx_seen);
                        deliver = (cur_kind == KIND_RAM_READ || cur_kind == KIND_FLASH_READ ||
                                   cur_kind == KIND_RDSR) && idx >= hlen;
                        rx_seen = rx_seen + 17'd1;
                        if (int'(rx_seen) >= total)
                        begin
                            rx_state     = PH_DONE;
                            done_bits[1] = 1'b1;
                            cs_active    = 1'b0;
                            last         = 1'b1;
                        end
                        else if (int'(rx_seen) >= hlen)
                            rx_state = PH_DATA;
                        if (deliver)
                        begin
                            r = '{out_kind: 1'b1, out_byte: w.data_byte, last_of_stream: last,
                                  select_active: cs_active, tx_done: done_bits[0],
                                  rx_done: done_bits[1]};
                            expected_bytes.push_back(r);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_response(rsp_word_t got);
            rsp_word_t want;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response word: kind %0d byte %02h last %0d",
                             got.out_kind, got.out_byte, got.last_of_stream);
            end
            else
            begin
                want = expected_bytes.pop_front();
                checked++;
                if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
                    got.last_of_stream !== want.last_of_stream ||
                    got.select_active !== want.select_active ||
                    got.tx_done !== want.tx_done || got.rx_done !== want.rx_done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display({"response %0d mismatch: expected kind %0d byte %02h",
                                  " last %0d cs %0d txd %0d rxd %0d"},
                                 checked, want.out_kind, want.out_byte, want.last_of_stream,
                                 want.select_active, want.tx_done, want.rx_done);
                        $display("    got kind %0d byte %02h last %0d cs %0d txd %0d rxd %0d",
                                 got.out_kind, got.out_byte, got.last_of_stream,
                                 got.select_active, got.tx_done, got.rx_done);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req_word  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;

    frame_scoreboard board = new();
    bit calm     = 1'b0;
    bit hold_rsp = 1'b0;
    int useful   = 0;
    int frames   = 0;
    int aborts   = 0;
    int idle_cycles = 0;

    spi_memory_command_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                board.note_request(req_word);
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp_word);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
                rsp_stall <= !calm && ($urandom_range(99) < 15);
        end
    end

    function automatic req_word_t word_of(logic [1:0] req, logic [2:0] cmd, logic [23:0] addr,
                                          logic [15:0] count, logic [7:0] data);
        req_word_t w;
        w = '{req_type: req, command: cmd, mem_address: addr, byte_count: count,
              data_byte: data};
        return w;
    endfunction

    task automatic send_word(input req_word_t w);
        int gap;
        begin
            if (!calm && $urandom_range(99) < 8)
            begin
                req_valid <= 1'b0;
                gap = $urandom_range(1, 3);
                repeat (gap) @(posedge clk);
            end
            req_valid <= 1'b1;
            req_word  <= w;
            @(posedge clk);
            while (req_stall) @(posedge clk);
        end
    endtask

    task automatic drain();
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while (board.pending() != 0) @(posedge clk);
        end
    endtask

    // stop_after < 0 runs the transaction to its end
    task automatic run_frame(input logic [2:0] kind, input logic [23:0] addr,
                             input logic [15:0] count, input int stop_after);
        int   len;
        int   tx_left;
        int   rx_left;
        int   sent;
        logic pick_tx;
        begin
            if (kind == KIND_RAM_WRITE || kind == KIND_FLASH_WRITE ||
                kind == KIND_RAM_READ || kind == KIND_FLASH_READ)
                len = int'(count);
            else
                len = (kind == KIND_RDSR) ? 1 : 0;
            tx_left = board.header_length(kind) + len;
            rx_left = tx_left;
            send_word(word_of(REQ_START, kind, addr, count, 8'($urandom)));
            useful++;
            frames++;
            sent = 0;
            while ((tx_left > 0 || rx_left > 0) && (stop_after < 0 || sent < stop_after))
            begin
                pick_tx = (tx_left > 0) && (rx_left == 0 || ($urandom_range(9) != 0 &&
                          (tx_left >= rx_left || $urandom_range(1) == 1)));
                send_word(word_of(pick_tx ? REQ_TX : REQ_RX, 3'($urandom), 24'($urandom),
                                  16'($urandom), 8'($urandom)));
                if (pick_tx)
                    tx_left--;
                else
                    rx_left--;
                sent++;
                useful++;
            end
            if (tx_left > 0 || rx_left > 0)
                aborts++;
            else if ($urandom_range(9) == 0)
                send_word(word_of($urandom_range(1) ? REQ_TX : REQ_RX, 3'($urandom),
                                  24'($urandom), 16'($urandom), 8'($urandom)));
        end
    endtask

    initial
    begin
        logic [2:0]  kind;
        logic [15:0] count;
        int          pick;
        int          stop;
        bit          pressed;
        bit          paused;
        pressed = 1'b0;
        paused  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray requests before any transaction
        send_word(word_of(REQ_TX, KIND_RDSR, 24'hFFFFFF, 16'hFFFF, 8'hFF));
        send_word(word_of(REQ_RX, KIND_RDSR, 24'hFFFFFF, 16'hFFFF, 8'hFF));
        send_word(word_of(REQ_NONE, KIND_RDSR, 24'hFFFFFF, 16'hFFFF, 8'hFF));
        run_frame(KIND_RAM_WRITE, 24'hFFFFFF, 16'hFFFF, 2);
        run_frame(KIND_FLASH_WRITE, 24'hFFFFFF, 16'd1, -1);
        send_word(word_of(REQ_TX, KIND_RAM_WRITE, 24'h0, 16'h0, 8'h00));
        send_word(word_of(REQ_RX, KIND_RAM_WRITE, 24'h0, 16'h0, 8'hFF));
        run_frame(KIND_FLASH_READ, 24'h000000, 16'd0, -1);
        drain();

        while (useful < ITEM_GOAL)
        begin
            calm = (useful >= 300 && useful < 500);
            if (!pressed && useful >= 700)
            begin
                hold_rsp = 1'b1;
                pressed  = 1'b1;
            end
            if (!paused && useful >= 1100)
            begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(19) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_word(word_of(2'($urandom_range(3)), 3'($urandom), 24'($urandom),
                                      16'($urandom), 8'($urandom)));
            end
            else
            begin
                kind = 3'($urandom);
                pick = $urandom_range(99);
                if (pick < 70)
                    count = 16'($urandom_range(1, 8));
                else if (pick < 90)
                    count = 16'($urandom_range(9, 40));
                else
                    count = 16'($urandom);
                if ((kind <= KIND_FLASH_READ && count > 40) || $urandom_range(9) == 0)
                    stop = $urandom_range(1, 30);
                else
                    stop = -1;
                run_frame(kind, 24'($urandom), count, stop);
            end
        end
        calm = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d transactions over all command kinds, %0d cut short by a new start,",
                 frames, aborts);
        $display("with stray requests; %0d response words checked, %0d mismatches",
                 board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
